// ----- rtl/core/highlight_strip_entity_decode_unit_macros.svh -----
// Assertion macros used by the entity decoder datapath.
`ifndef HIGHLIGHT_STRIP_ENTITY_DECODE_UNIT_MACROS_SVH
`define HIGHLIGHT_STRIP_ENTITY_DECODE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsed assertion failed");

// Next-cycle implication, disabled during reset.
`define HSED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsed assertion failed");

`endif

// ----- rtl/core/hsed_pkg.sv -----
// Shared types, constants and helpers of the entity decoder.
package hsed_pkg;

    // Default depth of the digit store.
    localparam int MAX_DIGITS_DEF = 8;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_MARK_A = 8'h02;
    localparam logic [7:0] CH_MARK_B = 8'h03;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] VAL_SAT   = 8'd128;

    // Parse phase held in the datapath.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_AMP    = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    // Source of the next result loaded into the output register.
    typedef enum logic [2:0] {
        EM_NONE = 3'd0,
        EM_STEP = 3'd1,
        EM_AMP  = 3'd2,
        EM_HASH = 3'd3,
        EM_DIG  = 3'd4,
        EM_TAIL = 3'd5
    } t_emit;

    // Controller to datapath.
    typedef struct packed {
        logic  accept;
        t_emit emit;
        logic  rd_first;
        logic  rd_next;
        logic  tail;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic need_flush;
        logic step_emits;
        logic ph_digits;
        logic cnt_zero;
        logic dig_last;
        logic tail_emits;
        logic out_free;
    } t_sts;

    // True when a byte seen in idle produces a result.
    function automatic logic idle_emits(input logic [7:0] b);
        idle_emits = !(b == CH_MARK_A || b == CH_MARK_B || b == CH_AMP);
    endfunction

endpackage

// ----- rtl/core/hsed_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hsed_ram #(
    parameter int W = 4,
    parameter int D = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/hsed_ctrl.sv -----
// Sequencing controller: input acceptance and flush of a broken reference.
module hsed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hsed_pkg::t_sts i_sts,
    output hsed_pkg::t_cmd o_cmd
);
    import hsed_pkg::*;

    typedef enum logic [4:0] {
        ST_IN   = 5'b00001,
        ST_AMP  = 5'b00010,
        ST_HASH = 5'b00100,
        ST_DIG  = 5'b01000,
        ST_TAIL = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    // Input is taken only in ST_IN with room in the output register
    assign o_stall = !(r_state == ST_IN && i_sts.out_free);

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        cmd.accept   = 1'b0;
        cmd.emit     = EM_NONE;
        cmd.rd_first = 1'b0;
        cmd.rd_next  = 1'b0;
        cmd.tail     = 1'b0;
        unique case (r_state)
            ST_IN: begin
                if (i_valid && i_sts.out_free) begin
                    cmd.accept = 1'b1;
                    if (i_sts.need_flush) begin
                        n_state = ST_AMP;
                    end else if (i_sts.step_emits) begin
                        cmd.emit = EM_STEP;
                    end
                end
            end
            ST_AMP: begin
                if (i_sts.out_free) begin
                    cmd.emit = EM_AMP;
                    n_state  = i_sts.ph_digits ? ST_HASH : ST_TAIL;
                end
            end
            ST_HASH: begin
                if (i_sts.out_free) begin
                    cmd.emit = EM_HASH;
                    if (i_sts.cnt_zero) begin
                        n_state = ST_TAIL;
                    end else begin
                        cmd.rd_first = 1'b1;
                        n_state      = ST_DIG;
                    end
                end
            end
            ST_DIG: begin
                if (i_sts.out_free) begin
                    cmd.emit = EM_DIG;
                    if (i_sts.dig_last) begin
                        n_state = ST_TAIL;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                // breaking byte handled as in idle
                if (!i_sts.tail_emits) begin
                    cmd.tail = 1'b1;
                    n_state  = ST_IN;
                end else if (i_sts.out_free) begin
                    cmd.tail = 1'b1;
                    cmd.emit = EM_TAIL;
                    n_state  = ST_IN;
                end
            end
            default: begin
                n_state = ST_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

// ----- rtl/core/hsed_dpath.sv -----
// Datapath: parse registers, digit store, value accumulator and output register.
`include "highlight_strip_entity_decode_unit_macros.svh"
module hsed_dpath #(
    parameter int MaxDigits = hsed_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_stall,
    input  logic [7:0]     i_in_byte,
    input  hsed_pkg::t_cmd i_cmd,
    output hsed_pkg::t_sts o_sts,
    output logic           o_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_run,
    output logic           o_end_of_string
);
    import hsed_pkg::*;

    localparam int AW = $clog2(MaxDigits);
    localparam int CW = $clog2(MaxDigits + 1);
    localparam logic [CW-1:0] CntMax = CW'(MaxDigits);

    t_phase         r_phase, n_phase;
    logic [CW-1:0]  r_count, n_count;
    logic [7:0]     r_val, n_val;
    logic [AW-1:0]  r_idx, n_idx;
    logic [7:0]     r_byte, n_byte;
    logic           r_o_valid, n_o_valid;
    logic [7:0]     r_o_byte, n_o_byte;
    logic           r_o_last, n_o_last;
    logic           r_o_eos, n_o_eos;

    logic           is_digit, room, step;
    logic [3:0]     digit;
    logic [10:0]    acc;
    logic [7:0]     sat_val;
    logic           need_flush, step_emits, tail_emits, dig_last, out_free;
    logic [7:0]     step_byte;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [3:0]     ram_rdata;

    // Input byte classification
    assign is_digit = (i_in_byte >= CH_ZERO) && (i_in_byte <= CH_NINE);
    assign digit    = i_in_byte[3:0];
    assign room     = r_count < CntMax;

    // value * 10 + digit, saturated at 128
    assign acc     = ({3'b000, r_val} << 3) + ({3'b000, r_val} << 1) + {7'd0, digit};
    assign sat_val = (acc > 11'(VAL_SAT)) ? VAL_SAT : acc[7:0];

    always_comb begin
        need_flush = 1'b0;
        step_emits = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                step_emits = idle_emits(i_in_byte);
            end
            PH_AMP: begin
                need_flush = (i_in_byte != CH_HASH);
            end
            PH_DIGITS: begin
                need_flush = !(is_digit && room) && (i_in_byte != CH_SEMI);
                step_emits = (i_in_byte == CH_SEMI);
            end
            default: begin
                step_emits = idle_emits(i_in_byte);
            end
        endcase
    end

    assign step_byte  = (r_phase == PH_DIGITS) ? ((r_val < VAL_SAT) ? r_val : CH_QUEST)
                                               : i_in_byte;
    assign tail_emits = idle_emits(r_byte);
    assign dig_last   = (CW'(r_idx) + CW'(1)) == r_count;
    assign out_free   = !r_o_valid || !i_stall;
    assign step       = i_cmd.accept && !need_flush;

    // Status to the controller
    assign o_sts.need_flush = need_flush;
    assign o_sts.step_emits = step_emits;
    assign o_sts.ph_digits  = (r_phase == PH_DIGITS);
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.dig_last   = dig_last;
    assign o_sts.tail_emits = tail_emits;
    assign o_sts.out_free   = out_free;

    // Parse state update
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_val   = r_val;
        n_byte  = r_byte;
        n_idx   = r_idx;
        ram_we  = 1'b0;
        if (step) begin
            unique case (r_phase)
                PH_AMP: begin
                    n_phase = PH_DIGITS;
                    n_count = '0;
                    n_val   = '0;
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        n_val   = sat_val;
                    end else begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                        n_val   = '0;
                    end
                end
                default: begin
                    n_phase = (i_in_byte == CH_AMP) ? PH_AMP : PH_IDLE;
                end
            endcase
        end
        if (i_cmd.accept && need_flush) begin
            n_byte = i_in_byte;
        end
        if (i_cmd.tail) begin
            n_phase = (r_byte == CH_AMP) ? PH_AMP : PH_IDLE;
            n_count = '0;
            n_val   = '0;
        end
        if (i_cmd.rd_first) begin
            n_idx = '0;
        end else if (i_cmd.rd_next) begin
            n_idx = r_idx + AW'(1);
        end
    end

    // Digit store read for flush
    assign ram_re    = i_cmd.rd_first || i_cmd.rd_next;
    assign ram_raddr = i_cmd.rd_first ? '0 : r_idx + AW'(1);

    hsed_ram #(
        .W (4),
        .D (MaxDigits)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (digit),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register load
    always_comb begin
        n_o_byte  = r_o_byte;
        n_o_last  = r_o_last;
        n_o_eos   = r_o_eos;
        n_o_valid = r_o_valid && i_stall;
        unique case (i_cmd.emit)
            EM_NONE: begin
            end
            EM_STEP: begin
                n_o_valid = 1'b1;
                n_o_byte  = step_byte;
                n_o_last  = 1'b1;
                n_o_eos   = (r_phase != PH_DIGITS) && (i_in_byte == CH_NUL);
            end
            EM_AMP: begin
                n_o_valid = 1'b1;
                n_o_byte  = CH_AMP;
                n_o_last  = (r_phase != PH_DIGITS) && !tail_emits;
                n_o_eos   = 1'b0;
            end
            EM_HASH: begin
                n_o_valid = 1'b1;
                n_o_byte  = CH_HASH;
                n_o_last  = (r_count == '0) && !tail_emits;
                n_o_eos   = 1'b0;
            end
            EM_DIG: begin
                n_o_valid = 1'b1;
                n_o_byte  = {CH_ZERO[7:4], ram_rdata};
                n_o_last  = dig_last && !tail_emits;
                n_o_eos   = 1'b0;
            end
            EM_TAIL: begin
                n_o_valid = 1'b1;
                n_o_byte  = r_byte;
                n_o_last  = 1'b1;
                n_o_eos   = (r_byte == CH_NUL);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_val     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_val     <= n_val;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_byte   <= n_byte;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
        r_o_eos  <= n_o_eos;
    end

    assign o_valid         = r_o_valid;
    assign o_out_byte      = r_o_byte;
    assign o_last_of_run   = r_o_last;
    assign o_end_of_string = r_o_eos;

    // A result never overwrites one that is still stalled
    `HSED_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.emit != EM_NONE, out_free)
    // Store writes stay inside the configured depth
    `HSED_ASSERT_IMPL(a_wr_in_range, i_clk, i_rst_n, ram_we, r_count < CntMax)
    // Saturated accumulator
    `HSED_ASSERT_IMPL(a_val_sat, i_clk, i_rst_n, r_phase == PH_DIGITS, r_val <= VAL_SAT)
    // Digits are flushed only from a reference that holds some
    `HSED_ASSERT_IMPL(a_dig_src, i_clk, i_rst_n, i_cmd.emit == EM_DIG,
                      r_phase == PH_DIGITS && r_count != '0)
    // Flush of the digit store starts at its first entry
    `HSED_ASSERT_NEXT(a_rd_first, i_clk, i_rst_n, i_cmd.rd_first, r_idx == '0)

endmodule

// ----- rtl/core/highlight_strip_entity_decode_unit.sv -----
// Top level of the highlight-stripping numeric entity decoder.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-----------------------------------------------
//   input   | i_valid | o_stall | i_in_byte
//   output  | o_valid | i_stall | o_out_byte, o_last_of_run, o_end_of_string
//
// A stream of bytes that each cause at most one result runs at one item per
// cycle while the output is not stalled. A broken reference flushes '&', then
// '#' and held digits from the digit store read port if '#' was seen, one per
// cycle unless the output stalls, then handles the breaking byte as in idle.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
// A stall on the output holds the output register and, through it, the input.
module highlight_strip_entity_decode_unit #(
    parameter int MaxDigits = hsed_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_string
);
    import hsed_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hsed_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hsed_dpath #(
        .MaxDigits (MaxDigits)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stall         (i_stall),
        .i_in_byte       (i_in_byte),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string)
    );

endmodule
